// File: rtl/hkvs_pkg.sv
// Package with shared types and constants for the hashed key/value set.
`default_nettype none
package hkvs_pkg;
  localparam int BUCKETS = 64;
  localparam int WAYS = 8;
  localparam int SLOTS = BUCKETS * WAYS;
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int AW = $clog2(SLOTS);
  localparam logic [31:0] HASH_MULT = 32'h61C88647;

  localparam logic [1:0] MODE_ADD = 2'd0;
  localparam logic [1:0] MODE_LOOKUP = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_DUP = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_MOD, S_SCAN, S_WAIT, S_DONE, S_OUT, S_CLEAR
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic clear;
    logic load;
    logic mul;
    logic mod_start;
    logic mod_step;
    logic scan_start;
    logic scan_step;
    logic finish;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clear_last;
    logic mod_done;
    logic scan_last;
  } sts_t;
endpackage
`default_nettype wire

// File: rtl/hashed_key_value_set.sv
// Top level of the hashed key/value set.
// Each transfer runs through these steps in order: the hash multiply, the
// bit-serial remainder by the configured modulus, clamped to 1..BUCKETS
// (one step per hash bit, then the bucket is handed over), reading the
// bucket's slots through the registered memory port, the update, presenting
// the result and idle, where the next item is accepted. A stall on the
// result holds the block until the result is taken. After reset a clearing
// pass over all BUCKETS valid words empties the valid bits, and the input stalls meanwhile.
// One item is in flight at a time.
`default_nettype none
module hashed_key_value_set
  import hkvs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_mode,
  input  wire logic signed [31:0] in_key,
  input  wire logic [31:0] in_data_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [31:0]      out_data_out,
  output logic [9:0]       out_entry_count,
  input  wire logic        cfg_we,
  input  wire logic [6:0]  cfg_data
);
  cmd_t cmd;
  sts_t sts;

  hkvs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd));

  hkvs_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_mode(in_mode), .in_key(in_key), .in_data_in(in_data_in),
    .out_status(out_status), .out_data_out(out_data_out),
    .out_entry_count(out_entry_count));

  // Never accept a new item while a result is pending.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("accept during result");
  // A finish is followed by a valid result.
  a_fin: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid) else $error("missing result");
  // Load happens only when idle.
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !in_stall) else $error("load while busy");
endmodule
`default_nettype wire

// File: rtl/hkvs_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module hkvs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Read before write (a write returns the old word), read registered.
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// File: rtl/hkvs_ctrl.sv
// Controller state machine sequencing hash, modulo and bucket scan.
`default_nettype none
module hkvs_ctrl
  import hkvs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);
  state_t state_r, state_nxt;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (sts.clear_last) state_nxt = S_IDLE;
      S_IDLE: if (in_valid) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_MOD;
      S_MOD:  if (sts.mod_done) state_nxt = S_SCAN;
      S_SCAN: if (sts.scan_last) state_nxt = S_WAIT;
      S_WAIT: state_nxt = S_DONE;
      S_DONE: state_nxt = S_OUT;
      S_OUT:  if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else state_r <= state_nxt;
  end

  // Outputs.
  always_comb begin
    cmd = '0;
    in_stall = (state_r != S_IDLE);
    out_valid = (state_r == S_OUT);
    case (state_r)
      S_CLEAR: cmd.clear = 1'b1;
      S_IDLE: cmd.load = in_valid;
      S_MUL:  begin cmd.mul = 1'b1; cmd.mod_start = 1'b1; end
      S_MOD:  begin
        cmd.mod_step = 1'b1;
        cmd.scan_start = sts.mod_done;
      end
      S_SCAN: cmd.scan_step = 1'b1;
      S_WAIT: cmd.scan_step = 1'b1;
      S_DONE: cmd.finish = 1'b1;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// File: rtl/hkvs_dp.sv
// Datapath: hash, serial modulo, slot memories and the bucket scan.
`default_nettype none
module hkvs_dp
  import hkvs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  output sts_t             sts,
  input  wire logic        cfg_we,
  input  wire logic [6:0]  cfg_data,
  input  wire logic [1:0]  in_mode,
  input  wire logic [31:0] in_key,
  input  wire logic [31:0] in_data_in,
  output logic [1:0]       out_status,
  output logic [31:0]      out_data_out,
  output logic [9:0]       out_entry_count
);
  logic [6:0]  cfg_r;
  logic [1:0]  mode_r;
  logic [31:0] key_r, data_r, hash_r;
  logic [31:0] rem_r, rem_nxt;
  logic [5:0]  bit_r;
  logic        mod_done_r;
  logic [6:0]  mod_m;
  logic [BW-1:0] bucket_r;
  logic [BW-1:0] clr_r;
  logic [WW:0]   ra_r, rb_r;
  logic          rv_r;
  logic        hit_r;
  logic [WW-1:0] hit_way_r;
  logic [31:0] hit_data_r;
  logic [9:0]  total_r;
  logic [31:0] key_q, data_q;
  logic        wr_en;
  logic [AW-1:0] addr;
  logic [WAYS-1:0] bv;
  logic          v_we;
  logic [BW-1:0] v_addr;
  logic [WAYS-1:0] v_wdata;
  logic        has_free;
  logic [WW-1:0] free_way;

  // Modulus clamped to 1..BUCKETS.
  always_comb begin
    if (cfg_r == 7'd0) mod_m = 7'd1;
    else if ({25'd0, cfg_r} > 32'(BUCKETS)) mod_m = 7'(BUCKETS);
    else mod_m = cfg_r;
  end

  // Restoring remainder, one hash bit per cycle.
  always_comb begin
    logic [32:0] t;
    t = {rem_r, hash_r[5'(bit_r)]};
    if (t >= {26'd0, mod_m}) t = t - {26'd0, mod_m};
    rem_nxt = t[31:0];
  end

  // Free way search over the bucket's valid bits.
  always_comb begin
    has_free = 1'b0;
    free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (!bv[w]) begin has_free = 1'b1; free_way = WW'(w); end
    end
  end

  always_comb begin
    wr_en = 1'b0;
    addr = AW'({bucket_r, ra_r[WW-1:0]});
    if (cmd.finish && mode_r == MODE_ADD && !hit_r && has_free) begin
      wr_en = 1'b1;
      addr = AW'({bucket_r, free_way});
    end
  end

  // Valid word of the bucket: cleared after reset, updated on finish.
  always_comb begin
    v_we = 1'b0;
    v_addr = bucket_r;
    v_wdata = bv;
    if (cmd.clear) begin
      v_we = 1'b1;
      v_addr = clr_r;
      v_wdata = '0;
    end else if (cmd.finish) begin
      case (mode_r)
        MODE_ADD: begin
          if (!hit_r && has_free) begin
            v_we = 1'b1;
            v_wdata[free_way] = 1'b1;
          end
        end
        MODE_REMOVE: begin
          if (hit_r) begin
            v_we = 1'b1;
            v_wdata[hit_way_r] = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  hkvs_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_key (
    .clk(clk), .we(wr_en), .addr(addr), .wdata(key_r), .rdata(key_q));
  hkvs_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_data (
    .clk(clk), .we(wr_en), .addr(addr), .wdata(data_r), .rdata(data_q));
  hkvs_ram #(.WIDTH(WAYS), .DEPTH(BUCKETS)) u_valid (
    .clk(clk), .we(v_we), .addr(v_addr), .wdata(v_wdata), .rdata(bv));

  assign sts.clear_last = (clr_r == BW'(BUCKETS - 1));
  assign sts.mod_done = mod_done_r;
  assign sts.scan_last = (ra_r == (WW+1)'(WAYS - 1)) || (ra_r == (WW+1)'(WAYS));

  // Payload registers and the read pipeline of the scan.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode; key_r <= in_key; data_r <= in_data_in;
    end
    if (cmd.mul) hash_r <= key_r * HASH_MULT;
    if (cmd.mod_start) begin
      rem_r <= '0; bit_r <= 6'd31; mod_done_r <= 1'b0;
    end else if (cmd.mod_step && !mod_done_r) begin
      rem_r <= rem_nxt;
      bit_r <= bit_r - 6'd1;
      if (bit_r == 6'd0) mod_done_r <= 1'b1;
    end
    if (cmd.scan_start) begin
      bucket_r <= BW'(rem_r);
      ra_r <= '0; rv_r <= 1'b0; hit_r <= 1'b0;
      hit_data_r <= '0;
    end else if (cmd.scan_step) begin
      if (ra_r != (WW+1)'(WAYS)) ra_r <= ra_r + 1'b1;
      rb_r <= ra_r;
      rv_r <= (ra_r != (WW+1)'(WAYS));
      if (rv_r && !hit_r && bv[rb_r[WW-1:0]] && key_q == key_r) begin
        hit_r <= 1'b1; hit_way_r <= rb_r[WW-1:0]; hit_data_r <= data_q;
      end
    end
  end

  // Clearing counter, modulus setting, key count and result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      total_r <= '0;
      cfg_r <= 7'd64;
    end else begin
      if (cmd.clear) clr_r <= clr_r + 1'b1;
      if (cfg_we) cfg_r <= cfg_data;
      if (cmd.finish) begin
        out_data_out <= '0;
        out_status <= ST_OK;
        case (mode_r)
          MODE_ADD: begin
            if (hit_r) out_status <= ST_DUP;
            else if (!has_free) out_status <= ST_FULL;
            else total_r <= total_r + 10'd1;
          end
          MODE_LOOKUP: begin
            if (hit_r) out_data_out <= hit_data_r;
            else out_status <= ST_MISS;
          end
          MODE_REMOVE: begin
            if (hit_r) total_r <= total_r - 10'd1;
            else out_status <= ST_MISS;
          end
          default: ;
        endcase
      end
    end
  end

  assign out_entry_count = total_r;
endmodule
`default_nettype wire
